>>> hw/rtl/atr_pkg.sv
`default_nettype none

package atr_pkg;

  localparam int MAX_READ = 1024;
  localparam int ADDR_W   = $clog2(MAX_READ);
  localparam int POS_W    = 11;
  localparam int SCORE_W  = 16;
  localparam int SUM_W    = SCORE_W + POS_W;

  localparam logic [7:0] BASE_N = 8'd78;

  localparam logic [2:0] KIND_START    = 3'd0;
  localparam logic [2:0] KIND_BASE     = 3'd1;
  localparam logic [2:0] KIND_INSERT   = 3'd2;
  localparam logic [2:0] KIND_DELETE   = 3'd3;
  localparam logic [2:0] KIND_SOFTCLIP = 3'd4;
  localparam logic [2:0] KIND_HARDCLIP = 3'd5;
  localparam logic [2:0] KIND_FINISH   = 3'd6;

  localparam logic [1:0] REG_MATCH    = 2'd0;
  localparam logic [1:0] REG_MISMATCH = 2'd1;
  localparam logic [1:0] REG_FLOOR    = 2'd2;

  localparam logic signed [4:0] MATCH_RESET    = 5'sd2;
  localparam logic signed [4:0] MISMATCH_RESET = -5'sd5;
  localparam logic signed [8:0] FLOOR_RESET    = -9'sd11;

  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       read_base;
    logic [7:0]       ref_base;
    logic [POS_W-1:0] seg_length;
  } atr_in_t;

  typedef struct packed {
    logic [POS_W-1:0] first_pos;
    logic [POS_W-1:0] end_pos;
    logic             overrun;
  } atr_out_t;

  typedef struct packed {
    logic                    init;
    logic                    step;
    logic [POS_W-1:0]        idx;
    logic [POS_W-1:0]        ridx;
    logic [POS_W-1:0]        size;
    logic signed [8:0]       score_floor;
  } atr_scan_ctrl_t;

  function automatic logic signed [SCORE_W-1:0] sat_add(
    input logic signed [SCORE_W-1:0] v,
    input logic signed [4:0]         d
  );
    logic signed [SCORE_W:0] s;
    s = (SCORE_W+1)'(v) + (SCORE_W+1)'(d);
    if (s > (SCORE_W+1)'(32767)) begin
      return 16'sh7fff;
    end else if (s < -(SCORE_W+1)'(32768)) begin
      return 16'sh8000;
    end
    return s[SCORE_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/atr_trim_scan.sv
`default_nettype none

module atr_trim_scan (
  input  wire logic                          clk,
  input  wire atr_pkg::atr_scan_ctrl_t       ctrl,
  input  wire logic signed [atr_pkg::SCORE_W-1:0] fwd_val,
  input  wire logic signed [atr_pkg::SCORE_W-1:0] rev_val,
  output logic [atr_pkg::POS_W-1:0]          first_pos,
  output logic [atr_pkg::POS_W-1:0]          end_pos
);
  import atr_pkg::*;

  logic signed [SUM_W-1:0] fsum;
  logic signed [SUM_W-1:0] fmin;
  logic signed [SUM_W-1:0] rsum;
  logic signed [SUM_W-1:0] rmin;
  logic signed [SUM_W-1:0] fsum_next;
  logic signed [SUM_W-1:0] rsum_next;

  assign fsum_next = fsum + SUM_W'(fwd_val);
  assign rsum_next = rsum + SUM_W'(rev_val);

  // The forward sum moves the begin past each new low point; the reverse
  // sum pulls the end back onto its own low points.
  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      fsum      <= '0;
      rsum      <= '0;
      fmin      <= SUM_W'(ctrl.score_floor);
      rmin      <= SUM_W'(ctrl.score_floor);
      first_pos <= '0;
      end_pos   <= ctrl.size;
    end else if (ctrl.step) begin
      fsum <= fsum_next;
      rsum <= rsum_next;
      if (fsum_next <= fmin) begin
        fmin      <= fsum_next;
        first_pos <= POS_W'(ctrl.idx + 1'b1);
      end
      if (rsum_next <= rmin) begin
        rmin    <= rsum_next;
        end_pos <= ctrl.ridx;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/alignment_trim_range_top.sv
`default_nettype none

// Start item: taken, then the clear state zeroes both score memories at each read position in turn.
// Aligned base, insertion or deletion that changes a score: a read, then a write back in the RMW state.
// Every other word except start and finish stays in idle. Finish: a scan with one read per memory
// per cycle feeds the sweep, then the result register waits for any stalled result to be taken.
// Synchronous reset clears control state and restores register defaults; the
// memories are not reset, as every entry is cleared by a start item before it is read.
module alignment_trim_range_top (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire atr_pkg::atr_in_t        in_data,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output atr_pkg::atr_out_t            out_data,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [1:0]              cfg_index,
  input  wire logic [8:0]              cfg_data
);
  import atr_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CLEAR  = 3'd1;
  localparam logic [2:0] ST_RMW    = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_REPORT = 3'd4;

  logic [2:0]        state, state_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [POS_W-1:0]  size, size_next;
  logic              ovr, ovr_next;
  logic [POS_W-1:0]  cnt, cnt_next;

  logic signed [4:0] match_gain;
  logic signed [4:0] mismatch_penalty;
  logic signed [8:0] score_floor;

  // Pending read-modify-write.
  logic              fwe_p, fwe_p_next;
  logic              rwe_p, rwe_p_next;
  logic [ADDR_W-1:0] fa, fa_next;
  logic [ADDR_W-1:0] ra, ra_next;
  logic signed [4:0] delta, delta_next;

  // Scan read pipeline.
  logic              p_valid;
  logic [POS_W-1:0]  p_idx;
  logic [POS_W-1:0]  p_ridx;

  logic signed [SCORE_W-1:0] fwd_mem [MAX_READ];
  logic signed [SCORE_W-1:0] rev_mem [MAX_READ];
  logic signed [SCORE_W-1:0] fwd_q, rev_q;
  logic              fwd_we, rev_we;
  logic [ADDR_W-1:0] fwd_wa, rev_wa, fwd_ra, rev_ra;
  logic signed [SCORE_W-1:0] fwd_wd, rev_wd;

  logic              accept;
  logic              issue;
  logic              out_free;
  logic [POS_W:0]    np;
  logic [POS_W:0]    last;
  logic [POS_W-1:0]  rpos;
  logic [POS_W-1:0]  begin_r, end_r;
  atr_scan_ctrl_t    scan_ctrl;

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign issue     = (state == ST_SCAN) && (cnt < size);
  assign np        = {1'b0, pos} + {1'b0, in_data.seg_length};
  assign last      = np - 1'b1;
  assign rpos      = POS_W'(size - cnt - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      match_gain       <= MATCH_RESET;
      mismatch_penalty <= MISMATCH_RESET;
      score_floor      <= FLOOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MATCH:    match_gain       <= cfg_data[4:0];
        REG_MISMATCH: mismatch_penalty <= cfg_data[4:0];
        REG_FLOOR:    score_floor      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    pos_next   = pos;
    size_next  = size;
    ovr_next   = ovr;
    cnt_next   = cnt;
    fwe_p_next = 1'b0;
    rwe_p_next = 1'b0;
    fa_next    = fa;
    ra_next    = ra;
    delta_next = delta;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data.kind)
            KIND_START: begin
              size_next = (in_data.seg_length > POS_W'(MAX_READ)) ?
                          POS_W'(MAX_READ) : in_data.seg_length;
              pos_next  = '0;
              ovr_next  = 1'b0;
              cnt_next  = '0;
              if (size_next != '0) begin
                state_next = ST_CLEAR;
              end
            end
            KIND_BASE: begin
              if (pos >= size) begin
                ovr_next = 1'b1;
              end else begin
                pos_next = POS_W'(pos + 1'b1);
                if (in_data.read_base != BASE_N && in_data.ref_base != BASE_N) begin
                  fwe_p_next = 1'b1;
                  rwe_p_next = 1'b1;
                  fa_next    = pos[ADDR_W-1:0];
                  ra_next    = pos[ADDR_W-1:0];
                  delta_next = (in_data.read_base == in_data.ref_base) ?
                               match_gain : mismatch_penalty;
                end
              end
            end
            KIND_INSERT: begin
              if (in_data.seg_length != '0) begin
                delta_next = mismatch_penalty;
                fa_next    = pos[ADDR_W-1:0];
                ra_next    = last[ADDR_W-1:0];
                if (pos < size) begin
                  fwe_p_next = 1'b1;
                end else begin
                  ovr_next = 1'b1;
                end
                // The last inserted base lands on the reverse store.
                if (last < {1'b0, size}) begin
                  rwe_p_next = 1'b1;
                end else begin
                  ovr_next = 1'b1;
                end
                if (np > {1'b0, size}) begin
                  ovr_next = 1'b1;
                  pos_next = size;
                end else begin
                  pos_next = np[POS_W-1:0];
                end
              end
            end
            KIND_DELETE: begin
              delta_next = mismatch_penalty;
              fa_next    = ADDR_W'(pos - 1'b1);
              ra_next    = pos[ADDR_W-1:0];
              fwe_p_next = (pos != '0);
              rwe_p_next = (pos < size);
            end
            KIND_SOFTCLIP: begin
              if (np > {1'b0, size}) begin
                ovr_next = 1'b1;
                pos_next = size;
              end else begin
                pos_next = np[POS_W-1:0];
              end
            end
            KIND_FINISH: begin
              cnt_next   = '0;
              state_next = ST_SCAN;
            end
            default: ;
          endcase
          if (fwe_p_next || rwe_p_next) begin
            state_next = ST_RMW;
          end
        end
      end
      ST_CLEAR: begin
        cnt_next = POS_W'(cnt + 1'b1);
        if (cnt_next == size) begin
          state_next = ST_IDLE;
        end
      end
      ST_RMW: begin
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        if (issue) begin
          cnt_next = POS_W'(cnt + 1'b1);
        end else if (!p_valid) begin
          state_next = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pos     <= '0;
      size    <= '0;
      ovr     <= 1'b0;
      cnt     <= '0;
      fwe_p   <= 1'b0;
      rwe_p   <= 1'b0;
      p_valid <= 1'b0;
    end else begin
      state   <= state_next;
      pos     <= pos_next;
      size    <= size_next;
      ovr     <= ovr_next;
      cnt     <= cnt_next;
      fwe_p   <= fwe_p_next;
      rwe_p   <= rwe_p_next;
      p_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    fa     <= fa_next;
    ra     <= ra_next;
    delta  <= delta_next;
    p_idx  <= cnt;
    p_ridx <= rpos;
  end

  // Reads come from the pending entry outside a scan and from both ends during a scan.
  always_comb begin
    if (state == ST_SCAN) begin
      fwd_ra = cnt[ADDR_W-1:0];
      rev_ra = rpos[ADDR_W-1:0];
    end else begin
      fwd_ra = fa_next;
      rev_ra = ra_next;
    end
  end

  always_comb begin
    if (state == ST_CLEAR) begin
      fwd_we = 1'b1;
      rev_we = 1'b1;
      fwd_wa = cnt[ADDR_W-1:0];
      rev_wa = cnt[ADDR_W-1:0];
      fwd_wd = '0;
      rev_wd = '0;
    end else begin
      fwd_we = (state == ST_RMW) && fwe_p;
      rev_we = (state == ST_RMW) && rwe_p;
      fwd_wa = fa;
      rev_wa = ra;
      fwd_wd = sat_add(fwd_q, delta);
      rev_wd = sat_add(rev_q, delta);
    end
  end

  always_ff @(posedge clk) begin
    if (fwd_we) begin
      fwd_mem[fwd_wa] <= fwd_wd;
    end
    fwd_q <= fwd_mem[fwd_ra];
  end

  always_ff @(posedge clk) begin
    if (rev_we) begin
      rev_mem[rev_wa] <= rev_wd;
    end
    rev_q <= rev_mem[rev_ra];
  end

  always_comb begin
    scan_ctrl.init        = accept && (in_data.kind == KIND_FINISH);
    scan_ctrl.step        = p_valid;
    scan_ctrl.idx         = p_idx;
    scan_ctrl.ridx        = p_ridx;
    scan_ctrl.size        = size;
    scan_ctrl.score_floor = score_floor;
  end

  atr_trim_scan u_scan (
    .clk       (clk),
    .ctrl      (scan_ctrl),
    .fwd_val   (fwd_q),
    .rev_val   (rev_q),
    .first_pos (begin_r),
    .end_pos   (end_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_REPORT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // An empty range is reported as zero at both ends.
  always_ff @(posedge clk) begin
    if (state == ST_REPORT && out_free) begin
      out_data.first_pos <= (end_r <= begin_r) ? '0 : begin_r;
      out_data.end_pos   <= (end_r <= begin_r) ? '0 : end_r;
      out_data.overrun   <= ovr;
    end
  end

`ifndef SYNTHESIS
  a_pos_in_read: assert property (@(posedge clk) disable iff (rst) pos <= size)
    else $error("read position beyond read length");
  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    size <= POS_W'(MAX_READ))
    else $error("read length beyond memory depth");
  a_rmw_one_cycle: assert property (@(posedge clk) disable iff (rst)
    state == ST_RMW |=> state == ST_IDLE)
    else $error("write back did not return to idle");
  a_scan_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN || state == ST_CLEAR) |-> cnt <= size)
    else $error("sweep counter past read length");
  a_range_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.end_pos == '0 || out_data.end_pos > out_data.first_pos))
    else $error("reported range is inverted");
`endif

endmodule

`default_nettype wire

>>> dv/alignment_trim_range_top_test.sv
`timescale 1ns / 1ps

module alignment_trim_range_top_test;
  import atr_pkg::*;

  localparam logic [2:0] KIND_UNUSED = 3'd7;
  localparam logic [1:0] REG_SPARE   = 2'd3;
  localparam logic [7:0] CH_A = 8'd65;
  localparam logic [7:0] CH_C = 8'd67;
  localparam logic [7:0] CH_G = 8'd71;
  localparam logic [7:0] CH_T = 8'd84;
  localparam int PLAN_LEN     = 27;
  localparam int RANDOM_WORDS = 1000;
  localparam int SETTLE       = 40;

  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       rb;
    logic [7:0]       fb;
    logic [POS_W-1:0] len;
    logic             typed;
    atr_out_t         range;
  } plan_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  atr_in_t    in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  atr_out_t   out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;

  alignment_trim_range_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Own copy of the score stores, walk state and registers.
  logic signed [SCORE_W-1:0] fwd_score [MAX_READ];
  logic signed [SCORE_W-1:0] rev_score [MAX_READ];
  int unsigned walk_pos;
  int unsigned walk_size;
  logic        walk_over;
  int          score_match;
  int          score_mism;
  int          floor_lvl;

  atr_out_t pending_range [$];
  int       faults = 0;
  int       shown = 0;
  int       sent_words = 0;
  int       burst_left = 0;
  int       stall_mode = 0;
  int       mode_left = 0;

  function automatic logic signed [SCORE_W-1:0] bump(logic signed [SCORE_W-1:0] v, int d);
    int s;
    s = int'(v) + d;
    if (s > 32767) begin
      s = 32767;
    end
    if (s < -32768) begin
      s = -32768;
    end
    return SCORE_W'(s);
  endfunction

  task automatic clear_scores();
    for (int i = 0; i < MAX_READ; i++) begin
      fwd_score[i] = '0;
      rev_score[i] = '0;
    end
  endtask

  task automatic advance_pos(int unsigned n);
    int unsigned np;
    np = walk_pos + n;
    if (np > walk_size) begin
      walk_over = 1'b1;
      np = walk_size;
    end
    walk_pos = np;
  endtask

  task automatic predict_trim(input atr_in_t w, output logic got, output atr_out_t r);
    int unsigned n;
    int unsigned last;
    int fsum, fmin, rsum, rmin, b, e, ri;
    got = 1'b0;
    r = '0;
    n = w.seg_length;
    case (w.kind)
      KIND_START: begin
        clear_scores();
        walk_size = (n > MAX_READ) ? MAX_READ : n;
        walk_pos = 0;
        walk_over = 1'b0;
      end
      KIND_BASE: begin
        if (walk_pos >= walk_size) begin
          walk_over = 1'b1;
        end else begin
          if (w.read_base != BASE_N && w.ref_base != BASE_N) begin
            e = (w.read_base == w.ref_base) ? score_match : score_mism;
            fwd_score[walk_pos] = bump(fwd_score[walk_pos], e);
            rev_score[walk_pos] = bump(rev_score[walk_pos], e);
          end
          walk_pos++;
        end
      end
      KIND_INSERT: begin
        if (n != 0) begin
          if (walk_pos < walk_size) begin
            fwd_score[walk_pos] = bump(fwd_score[walk_pos], score_mism);
          end else begin
            walk_over = 1'b1;
          end
          last = walk_pos + n - 1;
          if (last < walk_size) begin
            rev_score[last] = bump(rev_score[last], score_mism);
          end else begin
            walk_over = 1'b1;
          end
          advance_pos(n);
        end
      end
      KIND_DELETE: begin
        if (walk_pos > 0 && walk_pos - 1 < walk_size) begin
          fwd_score[walk_pos-1] = bump(fwd_score[walk_pos-1], score_mism);
        end
        if (walk_pos < walk_size) begin
          rev_score[walk_pos] = bump(rev_score[walk_pos], score_mism);
        end
      end
      KIND_SOFTCLIP: begin
        advance_pos(n);
      end
      KIND_HARDCLIP: ;
      KIND_FINISH: begin
        b = 0;
        e = walk_size;
        fsum = 0;
        rsum = 0;
        fmin = floor_lvl;
        rmin = floor_lvl;
        for (int i = 0; i < walk_size; i++) begin
          ri = walk_size - i - 1;
          fsum += int'(fwd_score[i]);
          if (fsum <= fmin) begin
            b = i + 1;
            fmin = fsum;
          end
          rsum += int'(rev_score[ri]);
          if (rsum <= rmin) begin
            e = ri;
            rmin = rsum;
          end
        end
        if (e <= b) begin
          b = 0;
          e = 0;
        end
        r.first_pos = POS_W'(b);
        r.end_pos = POS_W'(e);
        r.overrun = walk_over;
        got = 1'b1;
      end
      default: ;
    endcase
  endtask

  function automatic plan_row_t rw(logic [2:0] k, logic [7:0] rb, logic [7:0] fb,
                                   logic [POS_W-1:0] len);
    plan_row_t p;
    p = '0;
    p.kind = k;
    p.rb = rb;
    p.fb = fb;
    p.len = len;
    return p;
  endfunction

  function automatic plan_row_t rt(logic [2:0] k, logic [POS_W-1:0] len, int b, int e,
                                   logic o);
    plan_row_t p;
    p = rw(k, 8'd0, 8'd0, len);
    p.typed = 1'b1;
    p.range.first_pos = POS_W'(b);
    p.range.end_pos = POS_W'(e);
    p.range.overrun = o;
    return p;
  endfunction

  // Directed walk, run under the reset register values.
  function automatic plan_row_t plan_row(int i);
    case (i)
      0:  return rt(KIND_FINISH, 11'd0, 0, 0, 1'b0);
      1:  return rw(KIND_BASE, CH_A, CH_A, 11'd0);
      2:  return rw(KIND_HARDCLIP, 8'd0, 8'd0, 11'd5);
      3:  return rt(KIND_FINISH, 11'd0, 0, 0, 1'b1);
      4:  return rw(KIND_UNUSED, 8'd255, 8'd255, 11'd2047);
      5:  return rw(KIND_START, 8'd0, 8'd0, 11'd8);
      6:  return rw(KIND_BASE, CH_A, CH_A, 11'd0);
      7:  return rw(KIND_BASE, BASE_N, CH_C, 11'd0);
      8:  return rw(KIND_BASE, CH_G, BASE_N, 11'd0);
      9:  return rw(KIND_BASE, 8'd0, 8'd255, 11'd0);
      10: return rw(KIND_INSERT, 8'd0, 8'd0, 11'd0);
      11: return rw(KIND_INSERT, 8'd0, 8'd0, 11'd2);
      12: return rw(KIND_DELETE, 8'd0, 8'd0, 11'd0);
      13: return rw(KIND_SOFTCLIP, 8'd0, 8'd0, 11'd0);
      14: return rw(KIND_BASE, 8'd255, 8'd255, 11'd0);
      15: return rw(KIND_SOFTCLIP, 8'd0, 8'd0, 11'd3);
      16: return rw(KIND_FINISH, 8'd0, 8'd0, 11'd0);
      17: return rw(KIND_FINISH, 8'd0, 8'd0, 11'd0);
      18: return rw(KIND_START, 8'd0, 8'd0, 11'd0);
      19: return rw(KIND_DELETE, 8'd0, 8'd0, 11'd0);
      20: return rt(KIND_FINISH, 11'd0, 0, 0, 1'b0);
      21: return rw(KIND_START, 8'd0, 8'd0, 11'd2047);
      22: return rt(KIND_FINISH, 11'd0, 0, MAX_READ, 1'b0);
      23: return rw(KIND_SOFTCLIP, 8'd0, 8'd0, 11'd2047);
      24: return rw(KIND_INSERT, 8'd0, 8'd0, 11'd1);
      25: return rw(KIND_DELETE, 8'd0, 8'd0, 11'd0);
      default: return rw(KIND_FINISH, 8'd0, 8'd0, 11'd0);
    endcase
  endfunction

  // The sender works in bursts; a gap follows the last word of each burst.
  task automatic send_word(input atr_in_t w, input logic typed, input atr_out_t fixed);
    logic got;
    atr_out_t r;
    int gap;
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    predict_trim(w, got, r);
    if (got) begin
      pending_range.push_back(typed ? fixed : r);
    end
    sent_words++;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
  endtask

  function automatic atr_in_t junk_word(logic [2:0] k);
    atr_in_t w;
    w.kind = k;
    w.read_base = 8'($urandom);
    w.ref_base = 8'($urandom);
    w.seg_length = POS_W'($urandom);
    return w;
  endfunction

  task automatic send_kind(logic [2:0] k);
    send_word(junk_word(k), 1'b0, '0);
  endtask

  task automatic send_len(logic [2:0] k, int len);
    atr_in_t w;
    w = junk_word(k);
    w.seg_length = POS_W'(len);
    send_word(w, 1'b0, '0);
  endtask

  function automatic logic [7:0] pick_base();
    case ($urandom_range(0, 9))
      0, 1: return CH_A;
      2, 3: return CH_C;
      4, 5: return CH_G;
      6, 7: return CH_T;
      8:    return BASE_N;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_base(logic force_n);
    atr_in_t w;
    w = junk_word(KIND_BASE);
    w.read_base = pick_base();
    w.ref_base = ($urandom_range(0, 1) == 0) ? w.read_base : pick_base();
    if (force_n) begin
      if ($urandom_range(0, 1) == 0) begin
        w.read_base = BASE_N;
      end else begin
        w.ref_base = BASE_N;
      end
    end
    send_word(w, 1'b0, '0);
  endtask

  // Lower valid and let the last result drain before touching the registers.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_range.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    logic [8:0] v;
    v = 9'(value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MATCH:    score_match = int'($signed(v[4:0]));
      REG_MISMATCH: score_mism = int'($signed(v[4:0]));
      REG_FLOOR:    floor_lvl = int'($signed(v));
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_scores(int m, int x, int f);
    write_reg(REG_MATCH, m);
    write_reg(REG_MISMATCH, x);
    write_reg(REG_FLOOR, f);
  endtask

  // One read: usually a start and a well-formed walk, sometimes broken.
  task automatic walk_read();
    int pick, len, target, plan, steps, seg;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      len = $urandom_range(0, 3);
    end else if (pick < 80) begin
      len = $urandom_range(4, 40);
    end else if (pick < 95) begin
      len = $urandom_range(41, 200);
    end else if (pick < 98) begin
      len = MAX_READ;
    end else begin
      len = $urandom_range(MAX_READ + 1, 2047);
    end
    target = (len > MAX_READ) ? MAX_READ : len;
    if ($urandom_range(0, 19) != 0) begin
      send_len(KIND_START, len);
    end
    plan = 0;
    steps = 0;
    if ($urandom_range(0, 4) == 0) begin
      seg = $urandom_range(0, 3);
      send_len(KIND_SOFTCLIP, seg);
      plan += seg;
    end
    while (plan < target && steps < 48) begin
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        send_base(1'b0);
        plan++;
      end else if (pick < 70) begin
        seg = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
        send_len(KIND_INSERT, seg);
        plan += seg;
      end else if (pick < 78) begin
        send_kind(KIND_DELETE);
      end else if (pick < 83) begin
        seg = $urandom_range(0, 6);
        send_len(KIND_SOFTCLIP, seg);
        plan += seg;
      end else if (pick < 87) begin
        send_kind(KIND_HARDCLIP);
      end else if (pick < 89) begin
        send_kind(KIND_UNUSED);
      end else if (pick < 91) begin
        send_kind(KIND_FINISH);
      end else begin
        send_base(1'b1);
        plan++;
      end
      steps++;
    end
    if (plan < target && $urandom_range(0, 1) == 0) begin
      send_len(KIND_SOFTCLIP, target - plan);
    end
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: repeat ($urandom_range(1, 3)) send_base(1'b0);
        1: send_len(KIND_INSERT, $urandom_range(1, 2047));
        2: send_len(KIND_SOFTCLIP, $urandom_range(1, 2047));
        default: send_kind(KIND_DELETE);
      endcase
    end
    send_kind(KIND_FINISH);
    if ($urandom_range(0, 9) == 0) begin
      send_kind(KIND_FINISH);
    end
  endtask

  task automatic note_fault(string what, atr_out_t want, atr_out_t got);
    faults++;
    if (shown < 10) begin
      shown++;
      $display("%0t: %s: expected begin %0d end %0d overrun %0d, got begin %0d end %0d overrun %0d",
               $realtime, what, want.first_pos, want.end_pos, want.overrun,
               got.first_pos, got.end_pos, got.overrun);
    end
  endtask

  always @(posedge clk) begin : check_range
    atr_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_range.size() == 0) begin
        note_fault("result with nothing expected", '0, out_data);
      end else begin
        want = pending_range.pop_front();
        if (out_data.first_pos !== want.first_pos || out_data.end_pos !== want.end_pos ||
            out_data.overrun !== want.overrun) begin
          note_fault("range mismatch", want, out_data);
        end
      end
    end
  end

  // The receiver switches between free running, light and heavy stalling.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(5, 200);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  initial begin : stimulus
    plan_row_t row;
    atr_in_t w;
    int phase;
    clear_scores();
    walk_pos = 0;
    walk_size = 0;
    walk_over = 1'b0;
    score_match = MATCH_RESET;
    score_mism = MISMATCH_RESET;
    floor_lvl = FLOOR_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < PLAN_LEN; i++) begin
      row = plan_row(i);
      w.kind = row.kind;
      w.read_base = row.rb;
      w.ref_base = row.fb;
      w.seg_length = row.len;
      send_word(w, row.typed, row.range);
    end
    wait_idle();

    phase = 0;
    while (sent_words < PLAN_LEN + RANDOM_WORDS) begin
      case (phase)
        0: set_scores(15, -16, 0);
        1: set_scores(-16, 15, -255);
        2: begin
          write_reg(REG_SPARE, $urandom_range(0, 511));
          set_scores(0, 0, -1);
        end
        default: begin
          if ($urandom_range(0, 2) != 0) begin
            write_reg(REG_MATCH, $urandom_range(0, 15));
            write_reg(REG_MISMATCH, -int'($urandom_range(0, 16)));
          end else begin
            write_reg(REG_MATCH, int'($urandom_range(0, 31)) - 16);
            write_reg(REG_MISMATCH, int'($urandom_range(0, 31)) - 16);
          end
          if ($urandom_range(0, 3) == 0) begin
            write_reg(REG_FLOOR, -int'($urandom_range(0, 255)));
          end else begin
            write_reg(REG_FLOOR, -int'($urandom_range(0, 30)));
          end
        end
      endcase
      repeat ($urandom_range(4, 10)) walk_read();
      wait_idle();
      phase++;
    end

    if (faults == 0 && pending_range.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
